// File: rtl/ecps_pkg.sv
// Package for the charge pilot state machine: state type, beat layouts,
// config register indexes and state code conversion. No dependencies.
`default_nettype none

package ecps_pkg;

    localparam int unsigned PilotW  = 3;
    localparam int unsigned CodeW   = 4;
    localparam int unsigned TimeW   = 32;
    localparam int unsigned CfgW    = 20;
    localparam int unsigned CfgIdxW = 2;

    // Pilot level codes
    localparam logic [PilotW-1:0] PL_12V   = 3'd0;
    localparam logic [PilotW-1:0] PL_9V    = 3'd1;
    localparam logic [PilotW-1:0] PL_6V    = 3'd2;
    localparam logic [PilotW-1:0] PL_DIODE = 3'd3;

    // Config register indexes
    localparam logic [CfgIdxW-1:0] CFG_UNUSED_TIMEOUT = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_NO_POWER_TIMEOUT = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_DISCONNECT_WAIT = 2'd2;

    localparam logic [CfgW-1:0] UNUSED_TIMEOUT_RST   = 20'd30000;
    localparam logic [CfgW-1:0] NO_POWER_TIMEOUT_RST = 20'd6000;
    localparam logic [CfgW-1:0] DISCONNECT_WAIT_RST  = 20'd3000;

    // External state codes
    localparam logic [CodeW-1:0] CODE_A      = 4'd0;
    localparam logic [CodeW-1:0] CODE_B      = 4'd1;
    localparam logic [CodeW-1:0] CODE_B1     = 4'd2;
    localparam logic [CodeW-1:0] CODE_C      = 4'd3;
    localparam logic [CodeW-1:0] CODE_C1     = 4'd4;
    localparam logic [CodeW-1:0] CODE_D      = 4'd5;
    localparam logic [CodeW-1:0] CODE_BUSB   = 4'd6;
    localparam logic [CodeW-1:0] CODE_BUSC   = 4'd7;
    localparam logic [CodeW-1:0] CODE_BUSBOK = 4'd8;
    localparam logic [CodeW-1:0] CODE_BUSCOK = 4'd9;

    typedef enum logic [9:0] {
        ST_A      = 10'b00_0000_0001,
        ST_B      = 10'b00_0000_0010,
        ST_B1     = 10'b00_0000_0100,
        ST_C      = 10'b00_0000_1000,
        ST_C1     = 10'b00_0001_0000,
        ST_D      = 10'b00_0010_0000,
        ST_BUSB   = 10'b00_0100_0000,
        ST_BUSC   = 10'b00_1000_0000,
        ST_BUSBOK = 10'b01_0000_0000,
        ST_BUSCOK = 10'b10_0000_0000
    } t_state;

    typedef struct packed {
        logic [CodeW-1:0] state_now;
        logic             standby_ready_evt;
        logic             vehicle_connected_evt;
        logic             not_enough_power_evt;
        logic             diode_ok_evt;
        logic             start_charging_evt;
        logic             disconnect_started_evt;
    } t_out_beat;

    // Code to state; codes above nine are not valid and map to standby
    function automatic t_state state_from_code(logic [CodeW-1:0] code);
        t_state s;
        case (code)
            CODE_A:      s = ST_A;
            CODE_B:      s = ST_B;
            CODE_B1:     s = ST_B1;
            CODE_C:      s = ST_C;
            CODE_C1:     s = ST_C1;
            CODE_D:      s = ST_D;
            CODE_BUSB:   s = ST_BUSB;
            CODE_BUSC:   s = ST_BUSC;
            CODE_BUSBOK: s = ST_BUSBOK;
            CODE_BUSCOK: s = ST_BUSCOK;
            default:     s = ST_A;
        endcase
        return s;
    endfunction

    function automatic logic [CodeW-1:0] code_from_state(t_state s);
        logic [CodeW-1:0] code;
        case (s)
            ST_A:      code = CODE_A;
            ST_B:      code = CODE_B;
            ST_B1:     code = CODE_B1;
            ST_C:      code = CODE_C;
            ST_C1:     code = CODE_C1;
            ST_D:      code = CODE_D;
            ST_BUSB:   code = CODE_BUSB;
            ST_BUSC:   code = CODE_BUSC;
            ST_BUSBOK: code = CODE_BUSBOK;
            ST_BUSCOK: code = CODE_BUSCOK;
            default:   code = CODE_A;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// File: rtl/ecps_in_if.sv
// Input channel of the charge pilot state machine: one loop tick per beat.
// Depends on ecps_pkg for field widths.
`default_nettype none

interface ecps_in_if;
    import ecps_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [PilotW-1:0]       pilot_level;
    logic                    error_present;
    logic                    charge_delayed;
    logic                    access_granted;
    logic                    is_worker_node;
    logic                    enough_current;
    logic [TimeW-1:0]        now_ms;
    logic                    force_valid;
    logic [CodeW-1:0]        force_state;

    modport source (
        output valid, pilot_level, error_present, charge_delayed, access_granted,
               is_worker_node, enough_current, now_ms, force_valid, force_state,
        input  ready
    );

    modport sink (
        input  valid, pilot_level, error_present, charge_delayed, access_granted,
               is_worker_node, enough_current, now_ms, force_valid, force_state,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/ecps_out_if.sv
// Result channel of the charge pilot state machine: state and event pulses.
// Depends on ecps_pkg for field widths.
`default_nettype none

interface ecps_out_if;
    import ecps_pkg::*;

    logic             valid;
    logic             ready;
    logic [CodeW-1:0] state_now;
    logic             standby_ready_evt;
    logic             vehicle_connected_evt;
    logic             not_enough_power_evt;
    logic             diode_ok_evt;
    logic             start_charging_evt;
    logic             disconnect_started_evt;

    modport source (
        output valid, state_now, standby_ready_evt, vehicle_connected_evt,
               not_enough_power_evt, diode_ok_evt, start_charging_evt,
               disconnect_started_evt,
        input  ready
    );

    modport sink (
        input  valid, state_now, standby_ready_evt, vehicle_connected_evt,
               not_enough_power_evt, diode_ok_evt, start_charging_evt,
               disconnect_started_evt,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/ev_charge_pilot_state_machine.sv
// Charge pilot state machine top level: ten-state charging FSM, three timers,
// config registers and an output register with skid. Uses ecps_pkg, ecps_*_if.
//
//   channel   dir  beat contents                          handshake
//   i_in      in   pilot level, flags, time, forced state valid/ready
//   o_out     out  state after tick, six event pulses     valid/ready
//   i_cfg_*   in   register index and 20-bit value        write enable only
//
// One tick per cycle while i_in.ready is high: a beat is evaluated in the cycle
// it is accepted and its result is written to the output register, or to the
// skid entry while o_out stalls; the state update is a single pass of compare logic.
// A two-entry output stage (output register plus skid) keeps i_in.ready
// independent of o_out.ready; input stalls only when both entries hold beats.
// Reset is synchronous, active low: standby, diode flag and timer armed flags cleared.
`default_nettype none

module ev_charge_pilot_state_machine (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    ecps_in_if.sink                           i_in,
    ecps_out_if.source                        o_out,
    input  wire                               i_cfg_we,
    input  wire  [ecps_pkg::CfgIdxW-1:0]      i_cfg_idx,
    input  wire  [ecps_pkg::CfgW-1:0]         i_cfg_data
);
    import ecps_pkg::*;

    // Config registers
    logic [CfgW-1:0] r_unused_limit, r_np_limit, r_disc_limit;

    // Machine state
    t_state           r_state, n_state;
    logic             r_diode, n_diode;
    logic             r_unused_armed, n_unused_armed;
    logic [TimeW-1:0] r_unused_start, n_unused_start;
    logic             r_np_armed, n_np_armed;
    logic [TimeW-1:0] r_np_start, n_np_start;
    logic             r_disc_armed, n_disc_armed;
    logic [TimeW-1:0] r_disc_start, n_disc_start;

    // Output stage
    t_out_beat r_out, r_skid, n_beat;
    logic      r_out_valid, r_skid_valid;

    logic       in_fire, out_fire;
    t_state     s_eff;
    logic       entered;
    logic [TimeW-1:0] unused_start_eff, np_start_eff;
    logic       unused_exp, np_exp, disc_exp;
    logic       ev_standby, ev_conn, ev_nopow, ev_diode, ev_start, ev_disc;

    assign i_in.ready = !r_skid_valid;
    assign in_fire    = i_in.valid && !r_skid_valid;
    assign out_fire   = r_out_valid && o_out.ready;

    // Config write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unused_limit <= UNUSED_TIMEOUT_RST;
            r_np_limit     <= NO_POWER_TIMEOUT_RST;
            r_disc_limit   <= DISCONNECT_WAIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_UNUSED_TIMEOUT:   r_unused_limit <= i_cfg_data;
                CFG_NO_POWER_TIMEOUT: r_np_limit     <= i_cfg_data;
                CFG_DISCONNECT_WAIT:  r_disc_limit   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Forced state applied ahead of the step; a change counts as an entry
    always_comb begin
        s_eff = r_state;
        if (i_in.force_valid && (i_in.force_state inside {[CODE_A:CODE_BUSCOK]})) begin
            s_eff = state_from_code(i_in.force_state);
        end
    end
    assign entered = (s_eff != r_state);

    // Timer starts as seen by this tick, and wrapping elapsed-time compares
    assign unused_start_eff = entered ? i_in.now_ms : r_unused_start;
    assign np_start_eff     = entered ? i_in.now_ms : r_np_start;
    assign unused_exp = (i_in.now_ms - unused_start_eff) >= {12'd0, r_unused_limit};
    assign np_exp     = (i_in.now_ms - np_start_eff) >= {12'd0, r_np_limit};
    assign disc_exp   = (i_in.now_ms - r_disc_start) >= {12'd0, r_disc_limit};

    // Next state and events for one tick
    always_comb begin
        n_state        = s_eff;
        n_diode        = entered ? 1'b0 : r_diode;
        n_unused_armed = r_unused_armed;
        n_unused_start = r_unused_start;
        n_np_armed     = r_np_armed;
        n_np_start     = r_np_start;
        n_disc_armed   = r_disc_armed;
        n_disc_start   = r_disc_start;
        ev_standby = 1'b0;
        ev_conn    = 1'b0;
        ev_nopow   = 1'b0;
        ev_diode   = 1'b0;
        ev_start   = 1'b0;
        ev_disc    = 1'b0;
        case (s_eff)
            ST_A, ST_B1, ST_BUSB: begin
                if (entered) n_unused_armed = 1'b0;
                if (i_in.pilot_level == PL_12V) begin
                    if (s_eff != ST_A) begin
                        n_state    = ST_A;
                        ev_standby = 1'b1;
                    end
                end else if (i_in.pilot_level == PL_9V) begin
                    if (!(i_in.error_present || i_in.charge_delayed ||
                          !i_in.access_granted || s_eff == ST_BUSB)) begin
                        ev_conn = 1'b1;
                        if (i_in.is_worker_node) begin
                            n_state = ST_BUSB;
                        end else begin
                            ev_nopow = !i_in.enough_current;
                            n_state  = ST_B;
                        end
                    end
                end
            end
            ST_B, ST_BUSC: begin
                n_unused_armed = entered ? 1'b1 : r_unused_armed;
                n_unused_start = unused_start_eff;
                if (i_in.pilot_level == PL_12V) begin
                    n_state = ST_A;
                end else if (i_in.pilot_level == PL_DIODE) begin
                    n_diode  = 1'b1;
                    ev_diode = 1'b1;
                end else if (i_in.pilot_level == PL_6V) begin
                    if (n_diode && !i_in.error_present && !i_in.charge_delayed) begin
                        if (i_in.is_worker_node) begin
                            n_state = ST_BUSC;
                        end else begin
                            n_unused_armed = 1'b0;
                            ev_start       = 1'b1;
                            n_state        = ST_C;
                        end
                    end
                end
                // timeout check runs even if this tick already moved on
                if (n_unused_armed && unused_exp) begin
                    n_unused_armed = 1'b0;
                    n_state        = ST_D;
                    ev_disc        = 1'b1;
                end
            end
            ST_C: begin
                if (entered) n_unused_armed = 1'b0;
                if (i_in.pilot_level == PL_12V) n_state = ST_A;
                else if (i_in.pilot_level == PL_9V) n_state = ST_D;
            end
            ST_C1: begin
                n_np_armed = entered ? 1'b1 : r_np_armed;
                n_np_start = np_start_eff;
                if (i_in.pilot_level == PL_12V) begin
                    n_np_armed = 1'b0;
                    n_state    = ST_A;
                end else if (i_in.pilot_level == PL_9V) begin
                    n_np_armed = 1'b0;
                    n_state    = ST_B1;
                end else if (n_np_armed && np_exp) begin
                    n_np_armed = 1'b0;
                    n_state    = ST_B1;
                end
            end
            ST_D: begin
                if (!r_disc_armed) begin
                    n_disc_armed = 1'b1;
                    n_disc_start = i_in.now_ms;
                end else if (disc_exp) begin
                    n_disc_armed = 1'b0;
                    n_state      = ST_B;
                end
            end
            ST_BUSBOK: n_state = ST_B;
            ST_BUSCOK: n_state = ST_C;
            default:   n_state = s_eff;
        endcase
    end

    always_comb begin
        n_beat.state_now              = code_from_state(n_state);
        n_beat.standby_ready_evt      = ev_standby;
        n_beat.vehicle_connected_evt  = ev_conn;
        n_beat.not_enough_power_evt   = ev_nopow;
        n_beat.diode_ok_evt           = ev_diode;
        n_beat.start_charging_evt     = ev_start;
        n_beat.disconnect_started_evt = ev_disc;
    end

    // Machine control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_A;
            r_diode        <= 1'b0;
            r_unused_armed <= 1'b0;
            r_np_armed     <= 1'b0;
            r_disc_armed   <= 1'b0;
        end else if (in_fire) begin
            r_state        <= n_state;
            r_diode        <= n_diode;
            r_unused_armed <= n_unused_armed;
            r_np_armed     <= n_np_armed;
            r_disc_armed   <= n_disc_armed;
        end
    end

    // Timer start stamps, only read while armed
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_unused_start <= n_unused_start;
            r_np_start     <= n_np_start;
            r_disc_start   <= n_disc_start;
        end
    end

    // Output register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || out_fire) begin
                r_out_valid  <= r_skid_valid || in_fire;
                r_skid_valid <= 1'b0;
            end else if (in_fire) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_fire) begin
            r_out <= r_skid_valid ? r_skid : n_beat;
        end
        if (in_fire) begin
            r_skid <= n_beat;
        end
    end

    assign o_out.valid                  = r_out_valid;
    assign o_out.state_now              = r_out.state_now;
    assign o_out.standby_ready_evt      = r_out.standby_ready_evt;
    assign o_out.vehicle_connected_evt  = r_out.vehicle_connected_evt;
    assign o_out.not_enough_power_evt   = r_out.not_enough_power_evt;
    assign o_out.diode_ok_evt           = r_out.diode_ok_evt;
    assign o_out.start_charging_evt     = r_out.start_charging_evt;
    assign o_out.disconnect_started_evt = r_out.disconnect_started_evt;

endmodule

`default_nettype wire
